>>> design/lsbc_pkg.sv
// Shared types and constants for the light sensor ball counter.
// Holds default sizes, register reset values and the register index codes.
// No dependencies.
package lsbc_pkg;

    localparam int WINDOW_LEN_DEF  = 200;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int THR_W   = 12;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0]          RISE_RESET  = 12'd200;
    localparam logic [THR_W-1:0]          FALL_RESET  = 12'd50;
    localparam logic signed [COUNT_W-1:0] EJECT_RESET = -16'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISE  = 2'd0,
        CFG_FALL  = 2'd1,
        CFG_EJECT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0] rise;
        logic [THR_W-1:0] fall;
    } t_thresh;

endpackage

>>> design/lsbc_tap_cell.sv
// One cell of the sample window: holds one sample of each sensor.
// Takes its neighbor's samples on every shift. Uses no package items.
module lsbc_tap_cell #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_intake,
    input  logic [SAMPLE_BITS-1:0] i_shooter,
    output logic [SAMPLE_BITS-1:0] o_intake,
    output logic [SAMPLE_BITS-1:0] o_shooter
);

    logic [SAMPLE_BITS-1:0] r_intake;
    logic [SAMPLE_BITS-1:0] r_shooter;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_intake  <= i_intake;
            r_shooter <= i_shooter;
        end
    end

    assign o_intake  = r_intake;
    assign o_shooter = r_shooter;

endmodule

>>> design/lsbc_baseline.sv
// Two-stage divide of a window sum by the window length.
// Reciprocal multiply, then one remainder correction. Uses no package items.
module lsbc_baseline #(
    parameter int WINDOW_LEN  = 200,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                          i_clk,
    input  logic                                          i_en_a,
    input  logic                                          i_en_b,
    input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0]     i_sum,
    output logic [SAMPLE_BITS-1:0]                        o_base
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int RCP_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SUM_W) / WINDOW_LEN);
    localparam logic [SUM_W-1:0] LEN_S = SUM_W'(WINDOW_LEN);

    logic [PROD_W-1:0]      r_prod;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_base;
    logic [SAMPLE_BITS-1:0] q_est;
    logic [SUM_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] n_base;

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
            r_sum  <= i_sum;
        end
    end

    always_comb begin
        q_est  = r_prod[SUM_W +: SAMPLE_BITS];
        rem    = r_sum - SUM_W'(q_est) * LEN_S;
        n_base = (rem >= LEN_S) ? q_est + SAMPLE_BITS'(1) : q_est;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_base <= n_base;
        end
    end

    assign o_base = r_base;

endmodule

>>> design/lsbc_detect.sv
// Hysteresis ball detector and wrapping counter for one sensor.
// Depends on lsbc_pkg for the threshold struct and counter width.
module lsbc_detect
    import lsbc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_full,
    input  logic [SAMPLE_BITS-1:0] i_base,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_thresh                i_thr,
    output logic                   o_event,
    output logic [COUNT_W-1:0]     o_count
);

    localparam int DIFF_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;

    logic                     r_disarmed;
    logic [COUNT_W-1:0]       r_count;
    logic                     n_disarmed;
    logic [COUNT_W-1:0]       n_count;
    logic [SAMPLE_BITS-1:0]   base;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] rise;
    logic signed [DIFF_W-1:0] fall;
    logic                     hit;

    always_comb begin
        base = i_full ? i_base : '0;
        diff = signed'(DIFF_W'(base)) - signed'(DIFF_W'(i_sample));
        rise = signed'(DIFF_W'(i_thr.rise));
        fall = signed'(DIFF_W'(i_thr.fall));
        hit  = !r_disarmed && (diff > rise);
        priority if (hit) begin
            n_disarmed = 1'b1;
        end else if (r_disarmed && (diff < fall)) begin
            n_disarmed = 1'b0;
        end else begin
            n_disarmed = r_disarmed;
        end
        n_count = r_count + COUNT_W'(hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disarmed <= 1'b0;
            r_count    <= '0;
        end else if (i_en) begin
            r_disarmed <= n_disarmed;
            r_count    <= n_count;
        end
    end

    assign o_event = hit;
    assign o_count = n_count;

endmodule

>>> design/light_sensor_ball_counter_core.sv
// Light sensor ball counter: moving-average baselines and hysteresis counting.
// A result word passes the input stage, the baseline multiply and divide registers and the output register.
// Throughput is one word per cycle while the output is not stalled; the window is a shift chain of tap cells.
// Synchronous active-low reset clears counts, sums, fill level and the pipeline,
// and restores the configuration registers to their defaults.
// Depends on lsbc_pkg, lsbc_tap_cell, lsbc_baseline and lsbc_detect.
module light_sensor_ball_counter_core
    import lsbc_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [SAMPLE_BITS-1:0]    i_intake_sample,
    input  logic [SAMPLE_BITS-1:0]    i_shooter_sample,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [COUNT_W-1:0]        o_intake_total,
    output logic [COUNT_W-1:0]        o_shot_total,
    output logic signed [COUNT_W-1:0] o_held_balls,
    output logic                      o_intake_event,
    output logic                      o_shot_event
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LEN);
    localparam logic [FILL_W-1:0] FILL_PRE = FILL_W'(WINDOW_LEN - 1);

    t_thresh                   r_thr;
    logic signed [COUNT_W-1:0] r_eject;

    logic [SAMPLE_BITS-1:0] w_tap_i [WINDOW_LEN+1];
    logic [SAMPLE_BITS-1:0] w_tap_s [WINDOW_LEN+1];

    logic [SUM_W-1:0]  r_sum_i;
    logic [SUM_W-1:0]  r_sum_s;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  n_sum_i;
    logic [SUM_W-1:0]  n_sum_s;
    logic [FILL_W-1:0] n_fill;
    logic              was_full;
    logic              in_acc;

    logic                   r_s1_valid;
    logic                   r_s1_full;
    logic [SAMPLE_BITS-1:0] r_s1_si;
    logic [SAMPLE_BITS-1:0] r_s1_ss;
    logic                   r_s2_valid;
    logic                   r_s2_full;
    logic [SAMPLE_BITS-1:0] r_s2_si;
    logic [SAMPLE_BITS-1:0] r_s2_ss;
    logic                   r_s3_valid;
    logic                   r_s3_full;
    logic [SAMPLE_BITS-1:0] r_s3_si;
    logic [SAMPLE_BITS-1:0] r_s3_ss;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic en_out;

    logic [SAMPLE_BITS-1:0] base_i;
    logic [SAMPLE_BITS-1:0] base_s;
    logic                   ev_i;
    logic                   ev_s;
    logic [COUNT_W-1:0]     cnt_i;
    logic [COUNT_W-1:0]     cnt_s;
    logic [COUNT_W-1:0]     n_held;

    logic                      r_out_valid;
    logic [COUNT_W-1:0]        r_intake_total;
    logic [COUNT_W-1:0]        r_shot_total;
    logic signed [COUNT_W-1:0] r_held;
    logic                      r_intake_event;
    logic                      r_shot_event;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.rise <= RISE_RESET;
            r_thr.fall <= FALL_RESET;
            r_eject    <= EJECT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RISE:  r_thr.rise <= i_cfg_data[THR_W-1:0];
                CFG_FALL:  r_thr.fall <= i_cfg_data[THR_W-1:0];
                CFG_EJECT: r_eject    <= signed'(i_cfg_data[COUNT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign rdy3       = !r_out_valid || i_out_ready;
    assign rdy2       = !r_s3_valid || rdy3;
    assign rdy1       = !r_s2_valid || rdy2;
    assign o_in_ready = !r_s1_valid || rdy1;
    assign in_acc     = i_in_valid && o_in_ready;
    assign en_out     = r_s3_valid && rdy3;

    assign w_tap_i[0] = i_intake_sample;
    assign w_tap_s[0] = i_shooter_sample;

    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_tap
        lsbc_tap_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_shift   (in_acc),
            .i_intake  (w_tap_i[k]),
            .i_shooter (w_tap_s[k]),
            .o_intake  (w_tap_i[k+1]),
            .o_shooter (w_tap_s[k+1])
        );
    end

    always_comb begin
        was_full = (r_fill == FILL_MAX);
        n_sum_i  = r_sum_i + SUM_W'(i_intake_sample)
                   - (was_full ? SUM_W'(w_tap_i[WINDOW_LEN]) : '0);
        n_sum_s  = r_sum_s + SUM_W'(i_shooter_sample)
                   - (was_full ? SUM_W'(w_tap_s[WINDOW_LEN]) : '0);
        n_fill   = was_full ? r_fill : r_fill + FILL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_i <= '0;
            r_sum_s <= '0;
            r_fill  <= '0;
        end else if (in_acc) begin
            r_sum_i <= n_sum_i;
            r_sum_s <= n_sum_s;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (rdy1) begin
                r_s2_valid <= r_s1_valid;
            end
            if (rdy2) begin
                r_s3_valid <= r_s2_valid;
            end
            if (rdy3) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_full <= was_full || (r_fill == FILL_PRE);
            r_s1_si   <= i_intake_sample;
            r_s1_ss   <= i_shooter_sample;
        end
        if (rdy1) begin
            r_s2_full <= r_s1_full;
            r_s2_si   <= r_s1_si;
            r_s2_ss   <= r_s1_ss;
        end
        if (rdy2) begin
            r_s3_full <= r_s2_full;
            r_s3_si   <= r_s2_si;
            r_s3_ss   <= r_s2_ss;
        end
    end

    lsbc_baseline #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_base_i (
        .i_clk  (i_clk),
        .i_en_a (rdy1),
        .i_en_b (rdy2),
        .i_sum  (r_sum_i),
        .o_base (base_i)
    );

    lsbc_baseline #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_base_s (
        .i_clk  (i_clk),
        .i_en_a (rdy1),
        .i_en_b (rdy2),
        .i_sum  (r_sum_s),
        .o_base (base_s)
    );

    lsbc_detect #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_det_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_out),
        .i_full   (r_s3_full),
        .i_base   (base_i),
        .i_sample (r_s3_si),
        .i_thr    (r_thr),
        .o_event  (ev_i),
        .o_count  (cnt_i)
    );

    lsbc_detect #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_det_s (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_out),
        .i_full   (r_s3_full),
        .i_base   (base_s),
        .i_sample (r_s3_ss),
        .i_thr    (r_thr),
        .o_event  (ev_s),
        .o_count  (cnt_s)
    );

    assign n_held = cnt_i - (COUNT_W'(r_eject) + cnt_s);

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_intake_total <= cnt_i;
            r_shot_total   <= cnt_s;
            r_held         <= signed'(n_held);
            r_intake_event <= ev_i;
            r_shot_event   <= ev_s;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_intake_total = r_intake_total;
    assign o_shot_total   = r_shot_total;
    assign o_held_balls   = r_held;
    assign o_intake_event = r_intake_event;
    assign o_shot_event   = r_shot_event;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for light_sensor_ball_counter_core: drives sample words, keeps its
// own model of the baselines, hysteresis and counters, and checks each result word.
// Depends on lsbc_pkg and the core with its submodules.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbc_pkg::*;

    localparam int WIN = WINDOW_LEN_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int TALLY_DEPTH = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] intake_total;
        logic [COUNT_W-1:0] shot_total;
        logic [COUNT_W-1:0] held_balls;
        logic               intake_event;
        logic               shot_event;
    } t_tally;

    typedef struct packed {
        logic [11:0] intake;
        logic [11:0] shooter;
        bit          typed;
        t_tally      want;
    } t_probe;

    // Before the window has filled the baselines are zero, so nothing counts and the
    // held count is zero minus the reset eject adjustment of minus one.
    localparam t_tally EMPTY_TALLY = '{16'd0, 16'd0, 16'd1, 1'b0, 1'b0};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [11:0]               i_intake_sample = '0;
    logic [11:0]               i_shooter_sample = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [COUNT_W-1:0]        o_intake_total;
    logic [COUNT_W-1:0]        o_shot_total;
    logic signed [COUNT_W-1:0] o_held_balls;
    logic                      o_intake_event;
    logic                      o_shot_event;

    light_sensor_ball_counter_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_probe probe_tab [20] = '{
        '{12'h000, 12'h000, 1'b1, EMPTY_TALLY},
        '{12'hFFF, 12'hFFF, 1'b1, EMPTY_TALLY},
        '{12'h000, 12'hFFF, 1'b1, EMPTY_TALLY},
        '{12'hFFF, 12'h000, 1'b1, EMPTY_TALLY},
        '{12'h800, 12'h7FF, 1'b1, EMPTY_TALLY},
        '{12'h7FF, 12'h800, 1'b1, EMPTY_TALLY},
        '{12'hAAA, 12'h555, 1'b1, EMPTY_TALLY},
        '{12'h555, 12'hAAA, 1'b1, EMPTY_TALLY},
        '{12'h001, 12'hFFE, 1'b1, EMPTY_TALLY},
        '{12'hFFE, 12'h001, 1'b1, EMPTY_TALLY},
        '{12'h100, 12'h080, 1'b1, EMPTY_TALLY},
        '{12'h040, 12'h020, 1'b1, EMPTY_TALLY},
        '{12'h010, 12'h008, 1'b1, EMPTY_TALLY},
        '{12'h004, 12'h002, 1'b1, EMPTY_TALLY},
        '{12'h002, 12'h004, 1'b1, EMPTY_TALLY},
        '{12'hFFF, 12'hFFF, 1'b1, EMPTY_TALLY},
        '{12'h000, 12'h000, 1'b1, EMPTY_TALLY},
        '{12'h123, 12'h456, 1'b1, EMPTY_TALLY},
        '{12'hC00, 12'h300, 1'b0, '0},
        '{12'h3FF, 12'hC00, 1'b0, '0}
    };

    // Model state.
    logic [11:0]        intake_hist [WIN];
    logic [11:0]        shooter_hist [WIN];
    int                 intake_sum = 0;
    int                 shooter_sum = 0;
    int                 fill_cnt = 0;
    int                 slot = 0;
    int                 intake_base = 0;
    int                 shooter_base = 0;
    bit                 intake_disarmed = 1'b0;
    bit                 shooter_disarmed = 1'b0;
    logic [COUNT_W-1:0] intake_cnt = '0;
    logic [COUNT_W-1:0] shot_cnt = '0;
    int                 rise_thr = int'(RISE_RESET);
    int                 fall_thr = int'(FALL_RESET);
    logic [COUNT_W-1:0] eject_adj = EJECT_RESET;

    t_tally tally_buf [TALLY_DEPTH];
    int     tally_wr = 0;
    int     tally_rd = 0;
    int     bad_fields = 0;
    int     quiet_cycles = 0;
    int     in_gap_pct = 0;
    int     out_stall_pct = 0;

    wire word_moved = (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                      || (i_cfg_valid && o_cfg_ready);

    function automatic bit dip_seen(input int base, input logic [11:0] s, inout bit disarmed);
        int diff;
        diff = base - int'(s);
        if (diff > rise_thr && !disarmed) begin
            disarmed = 1'b1;
            return 1'b1;
        end
        if (diff < fall_thr && disarmed)
            disarmed = 1'b0;
        return 1'b0;
    endfunction

    function automatic t_tally count_tick(input logic [11:0] si, input logic [11:0] ss);
        t_tally r;
        bit     full;
        full = (fill_cnt >= WIN);
        if (full) begin
            intake_sum -= int'(intake_hist[slot]);
            shooter_sum -= int'(shooter_hist[slot]);
        end
        intake_hist[slot] = si;
        shooter_hist[slot] = ss;
        intake_sum += int'(si);
        shooter_sum += int'(ss);
        slot = (slot + 1 == WIN) ? 0 : slot + 1;
        if (!full)
            fill_cnt++;
        if (fill_cnt >= WIN) begin
            intake_base = intake_sum / WIN;
            shooter_base = shooter_sum / WIN;
        end
        r.shot_event = dip_seen(shooter_base, ss, shooter_disarmed);
        r.intake_event = dip_seen(intake_base, si, intake_disarmed);
        if (r.shot_event)
            shot_cnt++;
        if (r.intake_event)
            intake_cnt++;
        r.intake_total = intake_cnt;
        r.shot_total = shot_cnt;
        r.held_balls = intake_cnt - (eject_adj + shot_cnt);
        return r;
    endfunction

    function automatic logic [11:0] shape_sample(input int level);
        int pick;
        int v;
        pick = int'($urandom_range(99));
        if (pick < 8)
            v = int'($urandom_range(4095));
        else if (pick < 22)
            v = level - int'($urandom_range(level));
        else
            v = level + int'($urandom_range(60)) - 30;
        if (v < 0)
            v = 0;
        else if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    task automatic push_word(input logic [11:0] si, input logic [11:0] ss,
                             input bit typed = 1'b0, input t_tally want = '0);
        t_tally p;
        while (int'($urandom_range(99)) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_intake_sample <= si;
        i_shooter_sample <= ss;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        p = count_tick(si, ss);
        tally_buf[tally_wr % TALLY_DEPTH] = typed ? want : p;
        tally_wr++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (tally_wr != tally_rd)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_RISE:  rise_thr = int'(data[11:0]);
            CFG_FALL:  fall_thr = int'(data[11:0]);
            CFG_EJECT: eject_adj = data;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            bad_fields++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tally_rd == tally_wr) begin
                bad_fields++;
                $error("result word with no expectation waiting");
            end else begin
                want = tally_buf[tally_rd % TALLY_DEPTH];
                tally_rd++;
                check_field("intake_total", int'(want.intake_total), int'(o_intake_total));
                check_field("shot_total", int'(want.shot_total), int'(o_shot_total));
                check_field("held_balls", int'($signed(want.held_balls)), int'(o_held_balls));
                check_field("intake_event", int'(want.intake_event), int'(o_intake_event));
                check_field("shot_event", int'(want.shot_event), int'(o_shot_event));
            end
        end
        i_out_ready <= (int'($urandom_range(99)) >= out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || word_moved)
            quiet_cycles <= 0;
        else if (quiet_cycles < QUIET_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          lvl_i;
        int          lvl_s;
        int          rise_pick;
        logic [3:0]  junk;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_gap_pct = 19;
        out_stall_pct = 76;
        foreach (probe_tab[k])
            push_word(probe_tab[k].intake, probe_tab[k].shooter, probe_tab[k].typed,
                      probe_tab[k].want);
        lvl_i = int'($urandom_range(4095, 600));
        lvl_s = int'($urandom_range(4095, 600));
        repeat (220)
            push_word(shape_sample(lvl_i), shape_sample(lvl_s));

        settle();
        cfg_write(CFG_SPARE, 16'hFFFF);
        cfg_write(CFG_RISE, 16'hFFFF);
        cfg_write(CFG_FALL, 16'h0000);
        cfg_write(CFG_EJECT, 16'h8000);
        i_cfg_valid <= 1'b0;
        repeat (25)
            push_word(shape_sample(lvl_i), shape_sample(lvl_s));
        settle();
        repeat (25)
            push_word(shape_sample(lvl_i), shape_sample(lvl_s));

        settle();
        in_gap_pct = 76;
        out_stall_pct = 19;
        cfg_write(CFG_RISE, 16'hF000);
        cfg_write(CFG_FALL, 16'h0FFF);
        cfg_write(CFG_EJECT, 16'h7FFF);
        i_cfg_valid <= 1'b0;
        repeat (40)
            push_word(shape_sample(lvl_i), shape_sample(lvl_s));

        settle();
        rise_pick = int'($urandom_range(800, 100));
        junk = 4'($urandom);
        cfg_write(CFG_RISE, {junk, 12'(rise_pick)});
        cfg_write(CFG_FALL, 16'($urandom_range(rise_pick)));
        cfg_write(CFG_EJECT, 16'($urandom));
        cfg_write(CFG_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
        lvl_i = int'($urandom_range(4095, 1000));
        lvl_s = int'($urandom_range(4095, 1000));
        repeat (50)
            push_word(shape_sample(lvl_i), shape_sample(lvl_s));

        // Held count wrap: dip the intake every other word and the shooter every fourth
        // word, with an eject adjustment that pushes the held count past its top.
        settle();
        in_gap_pct = 0;
        out_stall_pct = 0;
        cfg_write(CFG_RISE, 16'hF0C8);
        cfg_write(CFG_FALL, 16'd50);
        cfg_write(CFG_EJECT, 16'h8001);
        i_cfg_valid <= 1'b0;
        for (int k = 0; k < 20; k++)
            push_word((k % 2 != 0) ? 12'hFFF : 12'h000, (k % 4 == 0) ? 12'h000 : 12'hFFF);

        settle();
        repeat (8) @(posedge i_clk);
        if (bad_fields == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
